// ----- hw/rtl/spwm_pkg.sv -----
// shared types, constants and helper functions of the serial pwm command decoder
`default_nettype none
package spwm_pkg;

  localparam int FRAME_DEPTH = 16;
  localparam int STORE_LEN   = FRAME_DEPTH - 1;
  localparam int CNT_W       = $clog2(STORE_LEN + 1);
  localparam int IDX_W       = $clog2(STORE_LEN);

  localparam int DUTY_W  = 7;
  localparam int MODE_W  = 2;
  localparam int WD_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_DUTY   = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PASSIVE = 2'd0,
    MODE_HALT    = 2'd1,
    MODE_ACTIVE  = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WD_RELOAD = 2'd1;

  localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_H    = 8'h68;  // 'h'
  localparam logic [BYTE_W-1:0] CH_P    = 8'h70;  // 'p'
  localparam logic [BYTE_W-1:0] CH_A    = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;  // '0'

  localparam logic [BYTE_W-1:0] DIGIT_MAX = 8'd9;
  localparam logic [DUTY_W-1:0] RADIX     = 7'd10;
  localparam logic [CNT_W-1:0]  A_FRAME_LEN = CNT_W'(9);

  localparam logic [DUTY_W-1:0] PWM_TOP_RST   = 7'd50;
  localparam logic [WD_W-1:0]   WD_RELOAD_RST = 16'd100;
  localparam logic [DUTY_W-1:0] DUTY_RST      = 7'd25;

  // true when the byte is an ascii decimal digit
  function automatic logic digit_ok(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    d = b - CH_ZERO;
    return d <= DIGIT_MAX;
  endfunction

  // two ascii digits to a value of 0..99
  function automatic logic [DUTY_W-1:0] pair_value(input logic [BYTE_W-1:0] hi,
                                                   input logic [BYTE_W-1:0] lo);
    logic [BYTE_W-1:0] dh;
    logic [BYTE_W-1:0] dl;
    dh = hi - CH_ZERO;
    dl = lo - CH_ZERO;
    return DUTY_W'(dh[3:0]) * RADIX + DUTY_W'(dl[3:0]);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/serial_pwm_command_decoder.sv -----
// top level of the serial pwm command decoder: framing, decode, duties and watchdog
`default_nettype none
// Takes one item per cycle (a serial byte or a timer tick) and returns one result per
// item: the four duty values and the mode after that item, with drive_enable and the
// two leds derived from the mode. An accepted transfer lands in an input register and
// is applied to the state once the result slot is free; the state and duty registers
// double as the result register. Sustained rate is one item per cycle, set only by
// out_stall. Framing keeps up to FRAME_DEPTH-1 bytes in a small register file; a duty
// command needs eight digits after the 'a'. Configuration is written through cfg_wr_en /
// cfg_index / cfg_data while idle, a rule for the user that the block does not enforce.
module serial_pwm_command_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_action,
  input  wire logic [spwm_pkg::BYTE_W-1:0]      in_rx_byte,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [spwm_pkg::DUTY_W-1:0]           out_duty_a,
  output logic [spwm_pkg::DUTY_W-1:0]           out_duty_b,
  output logic [spwm_pkg::DUTY_W-1:0]           out_duty_c,
  output logic [spwm_pkg::DUTY_W-1:0]           out_duty_d,
  output logic [spwm_pkg::MODE_W-1:0]           out_mode,
  output logic                                  out_drive_enable,
  output logic                                  out_green_led,
  output logic                                  out_blue_led,
  // configuration port
  input  wire logic                             cfg_wr_en,
  input  wire logic [spwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spwm_pkg::*;

  // configuration registers
  logic [DUTY_W-1:0] pwm_top_r;
  logic [WD_W-1:0]   wd_reload_r;

  // input register
  logic              s1_valid_r;
  logic              s1_action_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // result valid
  logic out_valid_r;

  // decoder state
  logic              frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0]  fill_count_r, fill_count_nxt;
  logic [BYTE_W-1:0] frame_store_r [STORE_LEN];
  mode_t             mode_r, mode_nxt;
  logic [DUTY_W-1:0] duty_r   [NUM_DUTY];
  logic [DUTY_W-1:0] duty_nxt [NUM_DUTY];
  logic [WD_W-1:0]   wd_count_r, wd_count_nxt;

  logic              store_we;
  logic              adv;
  logic              s1_fire;

  // per-pair decode of a duty command
  logic [DUTY_W-1:0] pair_val [NUM_DUTY];
  logic [NUM_DUTY-1:0] pair_ok;
  logic              a_ok;
  logic [DUTY_W-1:0] half_top;

  // the result slot frees up when empty or being taken this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign half_top = pwm_top_r >> 1;

  // digits live at fixed frame positions 1..8, checked in parallel
  always_comb begin
    for (int k = 0; k < NUM_DUTY; k++) begin
      pair_val[k] = pair_value(frame_store_r[1 + 2 * k], frame_store_r[2 + 2 * k]);
      pair_ok[k]  = digit_ok(frame_store_r[1 + 2 * k]) &&
                    digit_ok(frame_store_r[2 + 2 * k]) &&
                    (pair_val[k] <= pwm_top_r);
    end
    a_ok = (fill_count_r >= A_FRAME_LEN) && (&pair_ok);
  end

  // state update for the item in the input register
  always_comb begin
    frame_open_nxt = frame_open_r;
    fill_count_nxt = fill_count_r;
    mode_nxt       = mode_r;
    wd_count_nxt   = wd_count_r;
    store_we       = 1'b0;
    for (int k = 0; k < NUM_DUTY; k++) duty_nxt[k] = duty_r[k];

    if (s1_fire) begin
      if (!s1_action_r) begin
        if (s1_byte_r == CH_PLUS) begin
          // open, or restart an open frame
          frame_open_nxt = 1'b1;
          fill_count_nxt = '0;
        end else if (s1_byte_r == CH_SEMI) begin
          if (frame_open_r) begin
            frame_open_nxt = 1'b0;
            fill_count_nxt = '0;
            if (fill_count_r != '0) begin
              if (frame_store_r[0] == CH_H) begin
                mode_nxt    = MODE_HALT;
                duty_nxt[0] = half_top;
                duty_nxt[1] = '0;
                duty_nxt[2] = half_top;
                duty_nxt[3] = half_top;
              end else if (frame_store_r[0] == CH_P) begin
                mode_nxt = MODE_PASSIVE;
              end else if (frame_store_r[0] == CH_A && a_ok) begin
                mode_nxt     = MODE_ACTIVE;
                wd_count_nxt = wd_reload_r;
                for (int k = 0; k < NUM_DUTY; k++) duty_nxt[k] = pair_val[k];
              end
            end
          end
        end else if (frame_open_r) begin
          if (fill_count_r < CNT_W'(STORE_LEN)) begin
            store_we       = 1'b1;
            fill_count_nxt = fill_count_r + 1'b1;
          end else begin
            // overflow drops the frame
            frame_open_nxt = 1'b0;
            fill_count_nxt = '0;
          end
        end
      end else if (mode_r == MODE_ACTIVE) begin
        // watchdog tick
        if (wd_count_r != '0) begin
          wd_count_nxt = wd_count_r - 1'b1;
        end else begin
          mode_nxt    = MODE_HALT;
          duty_nxt[0] = half_top;
          duty_nxt[1] = '0;
          duty_nxt[2] = half_top;
          duty_nxt[3] = half_top;
        end
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_top_r    <= PWM_TOP_RST;
      wd_reload_r  <= WD_RELOAD_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      frame_open_r <= 1'b0;
      fill_count_r <= '0;
      mode_r       <= MODE_PASSIVE;
      wd_count_r   <= '0;
      for (int k = 0; k < NUM_DUTY; k++) duty_r[k] <= DUTY_RST;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_PWM_TOP) begin
          pwm_top_r <= cfg_data[DUTY_W-1:0];
        end else if (cfg_index == CFG_WD_RELOAD) begin
          wd_reload_r <= cfg_data[WD_W-1:0];
        end
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      frame_open_r <= frame_open_nxt;
      fill_count_r <= fill_count_nxt;
      mode_r       <= mode_nxt;
      wd_count_r   <= wd_count_nxt;
      for (int k = 0; k < NUM_DUTY; k++) duty_r[k] <= duty_nxt[k];
    end
  end

  // input payload register, no reset
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
    end
  end

  // frame byte store, written at the fill position
  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store_r[fill_count_r[IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // result outputs come straight from the state registers
  assign out_valid        = out_valid_r;
  assign out_duty_a       = duty_r[0];
  assign out_duty_b       = duty_r[1];
  assign out_duty_c       = duty_r[2];
  assign out_duty_d       = duty_r[3];
  assign out_mode         = mode_r;
  assign out_drive_enable = (mode_r != MODE_PASSIVE);
  assign out_green_led    = (mode_r != MODE_HALT);
  assign out_blue_led     = (mode_r != MODE_PASSIVE);

`ifndef SYNTHESIS
  // a closed frame holds no bytes
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> (fill_count_r == '0))
    else $error("closed frame with nonzero fill count");

  // fill count stays within the store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(STORE_LEN))
    else $error("fill count beyond store length");

  // stall only backs up a held item
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

  // an active tick with time left counts down by one
  a_wd_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_action_r && mode_r == MODE_ACTIVE && wd_count_r != '0)
      |=> (wd_count_r == $past(wd_count_r) - 1'b1) && (mode_r == MODE_ACTIVE))
    else $error("watchdog did not count down");
`endif

endmodule
`default_nettype wire
